// File: design/mrs_pkg.sv
// package: shared types and constants of the masked region statistics unit
`timescale 1ns / 1ps
package mrs_pkg;

    localparam int MAX_PIXELS  = 1048576;
    localparam int CNT_W       = 21;
    localparam int BSUM_W      = 28;
    localparam int VOL_W       = 29;
    localparam int PIX_W       = 8;
    localparam int HGT_W       = 9;
    localparam int HEIGHT_CEIL = 255;
    localparam int DIV_N       = 28;

    typedef struct packed {
        logic [CNT_W-1:0]         area;
        logic [BSUM_W-1:0]        bsum;
        logic [CNT_W-1:0]         bcount;
        logic [PIX_W-1:0]         max_h;
        logic signed [HGT_W-1:0]  min_h;
        logic signed [VOL_W-1:0]  volume;
    } t_snap;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_OUT
    } t_back_state;

endpackage

// File: design/masked_region_statistics_unit.sv
// top level of the masked region statistics unit
//
// pixel channel: i_pixel_valid / o_pixel_ready carry one pixel item with its
// mask bit and last flag; one item is taken per cycle while the snapshot
// queue has room. the item flagged last closes the frame.
// result channel: o_result_valid / i_result_ready carry one result item per
// frame. after the last pixel is taken, its snapshot passes through the queue,
// the back part loads it into the two bit-serial dividers, which work in
// parallel, and the result is registered when both are done.
// the back part handles one frame at a time and takes the next snapshot
// only after the receiver has taken the result.
// a stalled receiver holds the result; the two-entry queue keeps taking
// frames until it fills, and then the pixel channel stalls.
// i_cfg_we writes the background level; it is used for pixel items
// accepted after the write.
// reset (synchronous, active low) clears the accumulators, empties the
// queue, drops the result and sets the background level to zero.
`timescale 1ns / 1ps
module masked_region_statistics_unit
    import mrs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [PIX_W-1:0]        i_cfg_data,
    input  logic                    i_pixel_valid,
    output logic                    o_pixel_ready,
    input  logic [PIX_W-1:0]        i_pixel,
    input  logic                    i_in_region,
    input  logic                    i_last_pixel,
    output logic                    o_result_valid,
    input  logic                    i_result_ready,
    output logic [CNT_W-1:0]        o_region_area,
    output logic [PIX_W-1:0]        o_background_mean,
    output logic [PIX_W-1:0]        o_max_height,
    output logic signed [HGT_W-1:0] o_min_height,
    output logic signed [VOL_W-1:0] o_region_volume,
    output logic signed [HGT_W-1:0] o_average_height,
    output logic                    o_region_empty,
    output logic                    o_background_empty
);

    t_snap push_snap;
    t_snap pop_snap;
    logic  push;
    logic  q_full;
    logic  q_valid;
    logic  q_pop;

    mrs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_pixel_valid),
        .o_ready      (o_pixel_ready),
        .i_pixel      (i_pixel),
        .i_in_region  (i_in_region),
        .i_last_pixel (i_last_pixel),
        .i_q_full     (q_full),
        .o_push       (push),
        .o_snap       (push_snap)
    );

    mrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_snap),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_data  (pop_snap)
    );

    mrs_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_q_data           (pop_snap),
        .o_q_pop            (q_pop),
        .o_valid            (o_result_valid),
        .i_ready            (i_result_ready),
        .o_region_area      (o_region_area),
        .o_background_mean  (o_background_mean),
        .o_max_height       (o_max_height),
        .o_min_height       (o_min_height),
        .o_region_volume    (o_region_volume),
        .o_average_height   (o_average_height),
        .o_region_empty     (o_region_empty),
        .o_background_empty (o_background_empty)
    );

endmodule

// File: design/mrs_front.sv
// front part: takes pixel items and accumulates the per-frame sums and extremes
`timescale 1ns / 1ps
module mrs_front
    import mrs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [PIX_W-1:0]   i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [PIX_W-1:0]   i_pixel,
    input  logic               i_in_region,
    input  logic               i_last_pixel,
    input  logic               i_q_full,
    output logic               o_push,
    output t_snap              o_snap
);

    logic [PIX_W-1:0]        r_level;
    logic [CNT_W-1:0]        r_total, n_total;
    logic [CNT_W-1:0]        r_area, n_area;
    logic [CNT_W-1:0]        r_bcount, n_bcount;
    logic [BSUM_W-1:0]       r_bsum, n_bsum;
    logic [PIX_W-1:0]        r_max, n_max;
    logic signed [HGT_W-1:0] r_min, n_min;
    logic signed [VOL_W-1:0] r_vol, n_vol;
    logic signed [HGT_W-1:0] h;
    logic                    accept;
    logic                    room;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && o_ready;
    assign room    = r_total < CNT_W'(MAX_PIXELS);
    assign h       = $signed({1'b0, i_pixel}) - $signed({1'b0, r_level});

    always_comb begin
        n_total  = r_total;
        n_area   = r_area;
        n_bcount = r_bcount;
        n_bsum   = r_bsum;
        n_max    = r_max;
        n_min    = r_min;
        n_vol    = r_vol;
        if (accept && room) begin
            n_total = r_total + CNT_W'(1);
            if (i_in_region) begin
                n_area = r_area + CNT_W'(1);
                if (h > $signed({1'b0, r_max})) begin
                    n_max = h[PIX_W-1:0];
                end
                if (h < r_min) begin
                    n_min = h;
                end
                n_vol = r_vol + VOL_W'(h);
            end else begin
                n_bcount = r_bcount + CNT_W'(1);
                n_bsum   = r_bsum + BSUM_W'(i_pixel);
            end
        end
    end

    assign o_push        = accept && i_last_pixel;
    assign o_snap.area   = n_area;
    assign o_snap.bsum   = n_bsum;
    assign o_snap.bcount = n_bcount;
    assign o_snap.max_h  = n_max;
    assign o_snap.min_h  = n_min;
    assign o_snap.volume = n_vol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level  <= '0;
            r_total  <= '0;
            r_area   <= '0;
            r_bcount <= '0;
            r_bsum   <= '0;
            r_max    <= '0;
            r_min    <= HGT_W'(HEIGHT_CEIL);
            r_vol    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_level <= i_cfg_data;
            end
            if (o_push) begin
                r_total  <= '0;
                r_area   <= '0;
                r_bcount <= '0;
                r_bsum   <= '0;
                r_max    <= '0;
                r_min    <= HGT_W'(HEIGHT_CEIL);
                r_vol    <= '0;
            end else begin
                r_total  <= n_total;
                r_area   <= n_area;
                r_bcount <= n_bcount;
                r_bsum   <= n_bsum;
                r_max    <= n_max;
                r_min    <= n_min;
                r_vol    <= n_vol;
            end
        end
    end

endmodule

// File: design/mrs_queue.sv
// two-entry queue of frame snapshots between front and back parts
`timescale 1ns / 1ps
module mrs_queue
    import mrs_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_snap i_data,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_snap o_data
);

    t_snap       r_mem [2];
    logic        r_wptr;
    logic        r_rptr;
    logic [1:0]  r_cnt;
    logic        do_push;
    logic        do_pop;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= !r_wptr;
            end
            if (do_pop) begin
                r_rptr <= !r_rptr;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// File: design/mrs_div.sv
// unsigned restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module mrs_div #(
    parameter int N = 28,
    parameter int D = 21
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [N-1:0] i_dividend,
    input  logic [D-1:0] i_divisor,
    output logic         o_busy,
    output logic [N-1:0] o_quotient
);

    localparam int CW = $clog2(N);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [D-1:0]  r_rem, n_rem;
    logic [N-1:0]  r_quo, n_quo;
    logic [D-1:0]  r_div;
    logic [D:0]    shifted;
    logic [D+1:0]  diff;

    assign shifted = {r_rem, r_quo[N-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_div};

    always_comb begin
        if (!diff[D+1]) begin
            n_rem = diff[D-1:0];
            n_quo = {r_quo[N-2:0], 1'b1};
        end else begin
            n_rem = shifted[D-1:0];
            n_quo = {r_quo[N-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == '0) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
            r_cnt <= CW'(N - 1);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
            r_cnt <= r_cnt - CW'(1);
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

// File: design/mrs_back.sv
// back part: runs the two divisions of a frame and holds the result item
`timescale 1ns / 1ps
module mrs_back
    import mrs_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_valid,
    input  t_snap                   i_q_data,
    output logic                    o_q_pop,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [CNT_W-1:0]        o_region_area,
    output logic [PIX_W-1:0]        o_background_mean,
    output logic [PIX_W-1:0]        o_max_height,
    output logic signed [HGT_W-1:0] o_min_height,
    output logic signed [VOL_W-1:0] o_region_volume,
    output logic signed [HGT_W-1:0] o_average_height,
    output logic                    o_region_empty,
    output logic                    o_background_empty
);

    t_back_state          r_state, n_state;
    t_snap                r_snap;
    logic                 start;
    logic                 load_out;
    logic                 mean_busy;
    logic                 avg_busy;
    logic [DIV_N-1:0]     mean_q;
    logic [DIV_N-1:0]     avg_q;
    logic [VOL_W-1:0]     vol_abs;
    logic                 r_neg;
    logic [HGT_W-1:0]     avg_mag;

    assign vol_abs = i_q_data.volume[VOL_W-1] ? VOL_W'(-i_q_data.volume)
                                              : VOL_W'(i_q_data.volume);
    assign avg_mag = {1'b0, avg_q[PIX_W-1:0]};

    mrs_div #(.N(DIV_N), .D(CNT_W)) u_mean_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_dividend (i_q_data.bsum),
        .i_divisor  (i_q_data.bcount),
        .o_busy     (mean_busy),
        .o_quotient (mean_q)
    );

    mrs_div #(.N(DIV_N), .D(CNT_W)) u_avg_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_dividend (vol_abs[DIV_N-1:0]),
        .i_divisor  (i_q_data.area),
        .o_busy     (avg_busy),
        .o_quotient (avg_q)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!mean_busy && !avg_busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        start    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            S_IDLE:  start = i_q_valid;
            S_DIV:   load_out = !mean_busy && !avg_busy;
            S_OUT:   start = 1'b0;
            default: start = 1'b0;
        endcase
    end

    assign o_q_pop = start;
    assign o_valid = r_state == S_OUT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_snap <= i_q_data;
            r_neg  <= i_q_data.volume[VOL_W-1];
        end
        if (load_out) begin
            o_region_area      <= r_snap.area;
            o_max_height       <= r_snap.max_h;
            o_min_height       <= r_snap.min_h;
            o_region_volume    <= r_snap.volume;
            o_region_empty     <= r_snap.area == '0;
            o_background_empty <= r_snap.bcount == '0;
            o_background_mean  <= (r_snap.bcount == '0) ? '0 : mean_q[PIX_W-1:0];
            if (r_snap.area == '0) begin
                o_average_height <= '0;
            end else if (r_neg) begin
                o_average_height <= -$signed(avg_mag);
            end else begin
                o_average_height <= $signed(avg_mag);
            end
        end
    end

`ifndef SYNTHESIS
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == S_IDLE && i_q_valid))
        else $error("snapshot taken outside idle");
    a_div_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> (mean_busy && avg_busy && r_state == S_DIV))
        else $error("dividers not running after start");
    a_region_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_region_empty) |->
            (o_average_height == '0 && o_region_volume == '0 && o_max_height == '0))
        else $error("empty region with nonzero statistics");
    a_bg_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_background_empty) |-> (o_background_mean == '0))
        else $error("empty background with nonzero mean");
`endif

endmodule
